// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define H2A_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition that must never be seen outside reset
`define H2A_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define H2A_ASSERT(lbl, clk, rstn, prop, msg)
`define H2A_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ----- rtl/core/h2a_pkg.sv -----
package h2a_pkg;

    localparam longint unsigned P_MAX_BUFFER_BYTES = 64'd65536;

    localparam logic [15:0] SHORT_LIMIT = 16'd4;
    localparam logic [15:0] HOLD_MIN_LEN = 16'd22;
    localparam logic [15:0] POS_LEN_SIZE = 16'd21;
    localparam logic [15:0] POS_NUM_ARRAYS = 16'd22;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_OVERRUN = 2'd2;

    localparam int MAX_RESULTS = 4;

    typedef enum logic [3:0] {
        PH_FIRST = 4'd0,
        PH_HOLD = 4'd1,
        PH_PASS = 4'd2,
        PH_HDR = 4'd3,
        PH_ATYPE = 4'd4,
        PH_CNT_HI = 4'd5,
        PH_CNT_LO = 4'd6,
        PH_SZ_HI = 4'd7,
        PH_SZ_LO = 4'd8,
        PH_DATA = 4'd9,
        PH_DONE = 4'd10
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [2:0] nls;
        logic       is_hvcc;
    } t_result;

    typedef struct packed {
        logic [2:0]                      cnt;
        t_result [MAX_RESULTS-1:0]       res;
    } t_step;

    function automatic t_result mk_res(input logic [7:0] b, input logic [1:0] kind,
                                       input logic [2:0] nls, input logic hv);
        t_result r;
        r.out_byte = b;
        r.kind = kind;
        r.nls = nls;
        r.is_hvcc = hv;
        return r;
    endfunction

endpackage

// ----- rtl/core/h2a_parser.sv -----
`include "assert_macros.svh"

module h2a_parser import h2a_pkg::*; #(
    parameter logic [15:0] POS_LIMIT = 16'hFFFF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_len,
    input  logic        i_eob,
    output t_step       o_step
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_held0, n_held0;
    logic [7:0]  r_held1, n_held1;
    logic [7:0]  r_arrays, n_arrays;
    logic [15:0] r_nals, n_nals;
    logic [15:0] r_nal_left, n_nal_left;
    logic [7:0]  r_hi, n_hi;
    logic [2:0]  r_len_size, n_len_size;
    logic        r_err, n_err;

    always_comb begin
        logic [15:0] nsize;
        logic [16:0] next_pos;
        logic [16:0] rem;
        logic [7:0]  arr_dec;
        logic [15:0] nal_dec;
        logic [15:0] left_dec;
        t_step       st;

        n_phase = r_phase;
        n_pos = r_pos;
        n_held0 = r_held0;
        n_held1 = r_held1;
        n_arrays = r_arrays;
        n_nals = r_nals;
        n_nal_left = r_nal_left;
        n_hi = r_hi;
        n_len_size = r_len_size;
        n_err = r_err;
        st = '0;

        nsize = {r_hi, i_byte};
        next_pos = {1'b0, r_pos} + 17'd1;
        rem = ({1'b0, i_len} > next_pos) ? ({1'b0, i_len} - next_pos) : 17'd0;
        arr_dec = r_arrays - 8'd1;
        nal_dec = r_nals - 16'd1;
        left_dec = r_nal_left - 16'd1;

        if (!r_err && r_phase != PH_DONE) begin
            if (r_phase == PH_FIRST && i_len < SHORT_LIMIT) begin
                st.res[0] = mk_res(8'd0, KIND_SHORT, r_len_size, 1'b0);
                st.cnt = 3'd1;
                n_err = 1'b1;
            end else if (r_pos < i_len) begin
                case (r_phase)
                    PH_FIRST: begin
                        if (i_len <= HOLD_MIN_LEN) begin
                            n_phase = PH_PASS;
                            st.res[0] = mk_res(i_byte, KIND_DATA, r_len_size, 1'b0);
                            st.cnt = 3'd1;
                        end else begin
                            n_held0 = i_byte;
                            n_phase = PH_HOLD;
                        end
                    end
                    PH_HOLD: begin
                        if (r_pos == 16'd1) begin
                            n_held1 = i_byte;
                        end else if (r_held0 != 8'd0 || r_held1 != 8'd0 || i_byte > 8'd1) begin
                            n_phase = PH_HDR;
                        end else begin
                            // annex b prefix already: release the held bytes
                            st.res[0] = mk_res(r_held0, KIND_DATA, r_len_size, 1'b0);
                            st.res[1] = mk_res(r_held1, KIND_DATA, r_len_size, 1'b0);
                            st.res[2] = mk_res(i_byte, KIND_DATA, r_len_size, 1'b0);
                            st.cnt = 3'd3;
                            n_phase = PH_PASS;
                        end
                    end
                    PH_PASS: begin
                        st.res[0] = mk_res(i_byte, KIND_DATA, r_len_size, 1'b0);
                        st.cnt = 3'd1;
                    end
                    PH_HDR: begin
                        if (r_pos == POS_LEN_SIZE) begin
                            n_len_size = {1'b0, i_byte[1:0]} + 3'd1;
                        end else if (r_pos == POS_NUM_ARRAYS) begin
                            n_arrays = i_byte;
                            n_phase = (i_byte != 8'd0) ? PH_ATYPE : PH_DONE;
                        end
                    end
                    PH_ATYPE: begin
                        n_phase = PH_CNT_HI;
                    end
                    PH_CNT_HI: begin
                        n_hi = i_byte;
                        n_phase = PH_CNT_LO;
                    end
                    PH_CNT_LO: begin
                        n_nals = nsize;
                        if (nsize != 16'd0) begin
                            n_phase = PH_SZ_HI;
                        end else begin
                            n_arrays = arr_dec;
                            n_phase = (arr_dec != 8'd0) ? PH_ATYPE : PH_DONE;
                        end
                    end
                    PH_SZ_HI: begin
                        n_hi = i_byte;
                        n_phase = PH_SZ_LO;
                    end
                    PH_SZ_LO: begin
                        if ({1'b0, nsize} > rem) begin
                            st.res[0] = mk_res(8'd0, KIND_OVERRUN, r_len_size, 1'b1);
                            st.cnt = 3'd1;
                            n_err = 1'b1;
                        end else begin
                            // start code 00 00 00 01
                            st.res[0] = mk_res(8'd0, KIND_DATA, r_len_size, 1'b1);
                            st.res[1] = mk_res(8'd0, KIND_DATA, r_len_size, 1'b1);
                            st.res[2] = mk_res(8'd0, KIND_DATA, r_len_size, 1'b1);
                            st.res[3] = mk_res(8'd1, KIND_DATA, r_len_size, 1'b1);
                            st.cnt = 3'd4;
                            if (nsize != 16'd0) begin
                                n_nal_left = nsize;
                                n_phase = PH_DATA;
                            end else begin
                                n_nals = nal_dec;
                                if (nal_dec != 16'd0) begin
                                    n_phase = PH_SZ_HI;
                                end else begin
                                    n_arrays = arr_dec;
                                    n_phase = (arr_dec != 8'd0) ? PH_ATYPE : PH_DONE;
                                end
                            end
                        end
                    end
                    PH_DATA: begin
                        st.res[0] = mk_res(i_byte, KIND_DATA, r_len_size, 1'b1);
                        st.cnt = 3'd1;
                        n_nal_left = left_dec;
                        if (left_dec == 16'd0) begin
                            n_nals = nal_dec;
                            if (nal_dec != 16'd0) begin
                                n_phase = PH_SZ_HI;
                            end else begin
                                n_arrays = arr_dec;
                                n_phase = (arr_dec != 8'd0) ? PH_ATYPE : PH_DONE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (r_pos < POS_LIMIT) begin
            n_pos = r_pos + 16'd1;
        end

        if (i_eob) begin
            // buffer ended while still deciding the format
            if (!n_err && n_phase == PH_HOLD) begin
                st.res[0] = mk_res(n_held0, KIND_DATA, r_len_size, 1'b0);
                st.cnt = 3'd1;
                if (r_pos >= 16'd1) begin
                    st.res[1] = mk_res(n_held1, KIND_DATA, r_len_size, 1'b0);
                    st.cnt = 3'd2;
                end
            end
            n_pos = '0;
            n_phase = PH_FIRST;
            n_held0 = '0;
            n_held1 = '0;
            n_arrays = '0;
            n_nals = '0;
            n_nal_left = '0;
            n_hi = '0;
            n_err = 1'b0;
        end

        o_step = st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_pos <= '0;
            r_held0 <= '0;
            r_held1 <= '0;
            r_arrays <= '0;
            r_nals <= '0;
            r_nal_left <= '0;
            r_hi <= '0;
            r_len_size <= 3'd1;
            r_err <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos <= n_pos;
            r_held0 <= n_held0;
            r_held1 <= n_held1;
            r_arrays <= n_arrays;
            r_nals <= n_nals;
            r_nal_left <= n_nal_left;
            r_hi <= n_hi;
            r_len_size <= n_len_size;
            r_err <= n_err;
        end
    end

    `H2A_NEVER(a_len_size_range, i_clk, i_rst_n, (r_len_size == 3'd0 || r_len_size > 3'd4), "length size out of range")
    `H2A_ASSERT(a_data_has_bytes, i_clk, i_rst_n, (r_phase == PH_DATA) |-> (r_nal_left != 16'd0), "payload phase with no bytes left")
    `H2A_ASSERT(a_err_phase, i_clk, i_rst_n, r_err |-> (r_phase == PH_FIRST || r_phase == PH_SZ_LO), "error latched in unexpected phase")

endmodule

// ----- rtl/core/hvcc_to_annexb_converter.sv -----
// hvcc to annex b converter
// input channel: one extradata byte per word (i_in_byte) with the buffer's
// total length (i_buffer_length) and an end flag on its final byte
// (i_end_of_buffer); handshake i_in_valid / o_in_ready
// output channel: one result per word (o_out_byte, o_result_kind,
// o_nal_length_size, o_is_hvcc, o_run_last); handshake o_out_valid /
// i_out_ready; o_run_last marks the final result of one input byte
// each byte passes through the input register, then the result queue,
// before its first result is offered
// throughput: one input byte per cycle while each byte gives at most one
// result and the receiver is ready; a byte giving more, such as the four
// results of a start code, holds the next byte until its last result leaves
// when the receiver stalls the queue holds its words, the input register
// fills and o_in_ready drops; nothing is lost or repeated
// reset (synchronous, active low) empties both registers and clears the
// parse state; the captured nal length size returns to one and, unlike the
// rest of the parse state, survives the end of a buffer
`include "assert_macros.svh"

module hvcc_to_annexb_converter import h2a_pkg::*; #(
    parameter longint unsigned MAX_BUFFER_BYTES = P_MAX_BUFFER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic [15:0] i_buffer_length,
    input  logic        i_end_of_buffer,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_nal_length_size,
    output logic        o_is_hvcc,
    output logic        o_run_last
);

    // byte position saturates at the smaller of 0xffff and one below the buffer limit
    localparam longint unsigned LIM_WIDE =
        ((MAX_BUFFER_BYTES - 64'd1) < 64'hFFFF) ? (MAX_BUFFER_BYTES - 64'd1) : 64'hFFFF;
    localparam logic [15:0] POS_LIMIT = LIM_WIDE[15:0];

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [15:0] r_in_len;
    logic        r_in_eob;

    // result queue: up to four words from one byte, drained in order
    t_result [MAX_RESULTS-1:0] r_res;
    logic [2:0]                r_q_cnt;
    logic [1:0]                r_q_rd;

    t_step step;
    logic  q_pop;
    logic  q_free;
    logic  fire;

    assign q_pop = o_out_valid && i_out_ready;
    // queue can take a new batch when empty or when its last word leaves now
    assign q_free = (r_q_cnt == 3'd0) || (r_q_cnt == 3'd1 && q_pop);
    assign fire = r_in_valid && q_free;
    assign o_in_ready = !r_in_valid || fire;

    h2a_parser #(
        .POS_LIMIT (POS_LIMIT)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (fire),
        .i_byte  (r_in_byte),
        .i_len   (r_in_len),
        .i_eob   (r_in_eob),
        .o_step  (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_len <= i_buffer_length;
            r_in_eob <= i_end_of_buffer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= '0;
            r_q_rd <= '0;
        end else if (fire) begin
            r_q_cnt <= step.cnt;
            r_q_rd <= '0;
        end else if (q_pop) begin
            r_q_cnt <= r_q_cnt - 3'd1;
            r_q_rd <= r_q_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= step.res;
        end
    end

    assign o_out_valid = (r_q_cnt != 3'd0);
    assign o_out_byte = r_res[r_q_rd].out_byte;
    assign o_result_kind = r_res[r_q_rd].kind;
    assign o_nal_length_size = r_res[r_q_rd].nls;
    assign o_is_hvcc = r_res[r_q_rd].is_hvcc;
    assign o_run_last = (r_q_cnt == 3'd1);

    `H2A_NEVER(a_q_cnt_max, i_clk, i_rst_n, (r_q_cnt > 3'd4), "result queue overfilled")
    `H2A_ASSERT(a_fire_when_free, i_clk, i_rst_n, fire |-> (r_q_cnt <= 3'd1), "new batch over pending words")
    `H2A_ASSERT(a_err_is_last, i_clk, i_rst_n, (o_out_valid && o_result_kind != KIND_DATA) |-> o_run_last, "error result not alone")
    `H2A_ASSERT(a_batch_shows, i_clk, i_rst_n, (fire && step.cnt != 3'd0) |=> o_out_valid, "loaded batch not offered")

endmodule

// ----- dv/hvcc_to_annexb_converter_test.sv -----
module hvcc_to_annexb_converter_test;
    import h2a_pkg::*;

    localparam int TOTAL_WORDS    = 315;
    localparam int HOLD_AT        = 120;   // receiver holds off here
    localparam int DRAIN_AT       = 220;   // sender waits for every result here
    localparam int CALM_AT        = 270;   // no idling from here on
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 10;

    // one result word as seen on the output channel
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] nls;
        logic       hvcc;
        logic       last;
    } t_annexb_word;

    // predicts the result words of every accepted byte and checks the output
    class t_annexb_scoreboard;
        t_annexb_word expected_words[$];
        t_annexb_word burst[$];
        int           mismatches;

        logic [15:0] offset;
        t_phase      stage;
        logic [7:0]  early[2];
        logic [7:0]  arrays_todo;
        logic [15:0] units_todo;
        logic [15:0] payload_todo;
        logic [7:0]  msb;
        logic [2:0]  length_size;
        logic        failed;

        function new();
            mismatches  = 0;
            length_size = 3'd1;
            restart();
        endfunction

        // everything but the captured length size goes back to reset
        function void restart();
            offset       = 16'd0;
            stage        = PH_FIRST;
            early[0]     = 8'h00;
            early[1]     = 8'h00;
            arrays_todo  = 8'd0;
            units_todo   = 16'd0;
            payload_todo = 16'd0;
            msb          = 8'd0;
            failed       = 1'b0;
        endfunction

        function void push_word(logic [7:0] b, logic [1:0] kind, logic hv);
            t_annexb_word w;
            w.data = b;
            w.kind = kind;
            w.nls  = length_size;
            w.hvcc = hv;
            w.last = 1'b0;
            if (burst.size() < MAX_RESULTS)
                burst.push_back(w);
        endfunction

        function void close_array();
            arrays_todo = arrays_todo - 8'd1;
            stage = (arrays_todo != 8'd0) ? PH_ATYPE : PH_DONE;
        endfunction

        function void close_unit();
            units_todo = units_todo - 16'd1;
            if (units_todo != 16'd0)
                stage = PH_SZ_HI;
            else
                close_array();
        endfunction

        function void note_byte(logic [7:0] b, logic [15:0] len, logic eob);
            logic [15:0] at;
            logic [16:0] next_at;
            logic [15:0] room;
            logic [15:0] unit_size;
            at = offset;
            burst.delete();
            if (!failed && stage != PH_DONE) begin
                if (stage == PH_FIRST && len < SHORT_LIMIT) begin
                    push_word(8'h00, KIND_SHORT, 1'b0);
                    failed = 1'b1;
                end else if (at < len) begin
                    case (stage)
                        PH_FIRST: begin
                            if (len <= HOLD_MIN_LEN) begin
                                stage = PH_PASS;
                                push_word(b, KIND_DATA, 1'b0);
                            end else begin
                                early[0] = b;
                                stage = PH_HOLD;
                            end
                        end
                        PH_HOLD: begin
                            if (at == 16'd1) begin
                                early[1] = b;
                            end else if (early[0] != 8'h00 || early[1] != 8'h00 || b > 8'd1) begin
                                stage = PH_HDR;
                            end else begin
                                // start code prefix: release the held bytes
                                push_word(early[0], KIND_DATA, 1'b0);
                                push_word(early[1], KIND_DATA, 1'b0);
                                push_word(b, KIND_DATA, 1'b0);
                                stage = PH_PASS;
                            end
                        end
                        PH_PASS: push_word(b, KIND_DATA, 1'b0);
                        PH_HDR: begin
                            if (at == POS_LEN_SIZE) begin
                                length_size = {1'b0, b[1:0]} + 3'd1;
                            end else if (at == POS_NUM_ARRAYS) begin
                                arrays_todo = b;
                                stage = (b != 8'd0) ? PH_ATYPE : PH_DONE;
                            end
                        end
                        PH_ATYPE: stage = PH_CNT_HI;
                        PH_CNT_HI: begin
                            msb = b;
                            stage = PH_CNT_LO;
                        end
                        PH_CNT_LO: begin
                            units_todo = {msb, b};
                            if (units_todo != 16'd0)
                                stage = PH_SZ_HI;
                            else
                                close_array();
                        end
                        PH_SZ_HI: begin
                            msb = b;
                            stage = PH_SZ_LO;
                        end
                        PH_SZ_LO: begin
                            unit_size = {msb, b};
                            next_at = {1'b0, at} + 17'd1;
                            room = ({1'b0, len} > next_at) ? len - next_at[15:0] : 16'd0;
                            if (unit_size > room) begin
                                push_word(8'h00, KIND_OVERRUN, 1'b1);
                                failed = 1'b1;
                            end else begin
                                push_word(8'h00, KIND_DATA, 1'b1);
                                push_word(8'h00, KIND_DATA, 1'b1);
                                push_word(8'h00, KIND_DATA, 1'b1);
                                push_word(8'h01, KIND_DATA, 1'b1);
                                if (unit_size != 16'd0) begin
                                    payload_todo = unit_size;
                                    stage = PH_DATA;
                                end else begin
                                    close_unit();
                                end
                            end
                        end
                        PH_DATA: begin
                            push_word(b, KIND_DATA, 1'b1);
                            payload_todo = payload_todo - 16'd1;
                            if (payload_todo == 16'd0)
                                close_unit();
                        end
                        default: ;
                    endcase
                end
            end
            // position saturates at the largest usable buffer offset
            if (offset != 16'hFFFF)
                offset = offset + 16'd1;
            if (eob) begin
                if (!failed && stage == PH_HOLD) begin
                    push_word(early[0], KIND_DATA, 1'b0);
                    if (at >= 16'd1)
                        push_word(early[1], KIND_DATA, 1'b0);
                end
                restart();
            end
            if (burst.size() != 0)
                burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i])
                expected_words.push_back(burst[i]);
        endfunction

        function void check_word(logic [7:0] b, logic [1:0] kind, logic [2:0] nls,
                                 logic hv, logic last);
            t_annexb_word want;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word byte=%h kind=%0d nls=%0d hvcc=%b last=%b",
                         $time, b, kind, nls, hv, last);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                if (want.data !== b || want.kind !== kind || want.nls !== nls ||
                    want.hvcc !== hv || want.last !== last) begin
                    $display("%0t: mismatch expected byte=%h kind=%0d nls=%0d hvcc=%b last=%b",
                             $time, want.data, want.kind, want.nls, want.hvcc, want.last);
                    $display("%0t:          actual   byte=%h kind=%0d nls=%0d hvcc=%b last=%b",
                             $time, b, kind, nls, hv, last);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic [15:0] i_buffer_length = 16'h0000;
    logic        i_end_of_buffer = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_result_kind;
    logic [2:0]  o_nal_length_size;
    logic        o_is_hvcc;
    logic        o_run_last;

    t_annexb_scoreboard sb;
    logic [7:0]       image[$];     // bytes of the buffer being built
    int               words_sent = 0;
    int               idle_cycles = 0;
    bit               calm = 1'b0;  // no idling on either side
    bit               hold_req = 1'b0;

    hvcc_to_annexb_converter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_byte         (i_in_byte),
        .i_buffer_length   (i_buffer_length),
        .i_end_of_buffer   (i_end_of_buffer),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_byte        (o_out_byte),
        .o_result_kind     (o_result_kind),
        .o_nal_length_size (o_nal_length_size),
        .o_is_hvcc         (o_is_hvcc),
        .o_run_last        (o_run_last)
    );

    always #1 i_clk = ~i_clk;

    // every word taken from the output is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_word(o_out_byte, o_result_kind, o_nal_length_size, o_is_hvcc, o_run_last);
    end

    // watchdog: too long without any word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[hvcc_to_annexb_converter] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall bursts, one long hold-off on request,
    // always ready once the run is calm
    initial begin
        int stall;
        stall = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end else if (stall == 0 && !calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 7);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // offers one word, with an occasional gap in front, and waits for it to be taken
    task automatic send_word(input logic [7:0] b, input logic [15:0] len, input logic eob);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_in_byte       <= b;
        i_buffer_length <= len;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(b, len, eob);
        words_sent++;
    endtask

    // sends the first count bytes of the image, end flag on the last one
    task automatic send_image(input int count, input logic [15:0] len);
        for (int i = 0; i < count; i++)
            send_word(image[i], len, i == count - 1);
    endtask

    // sender stops and waits until every predicted word has come out
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            image.push_back(8'($urandom));
    endtask

    // hvcc record: 23 header bytes, then arrays of length-prefixed nal units
    task automatic hvcc_buffer();
        int          n_arrays;
        int          n_units;
        int          unit_len;
        int          full;
        int          form;
        logic [15:0] len;
        image.delete();
        case ($urandom_range(0, 3))
            0: begin
                image.push_back(8'h01);
                push_random(2);
            end
            1: begin
                image.push_back(8'h00);
                image.push_back(8'h00);
                image.push_back(8'($urandom_range(2, 255)));
            end
            2: begin
                image.push_back(8'h00);
                image.push_back(8'($urandom_range(1, 255)));
                push_random(1);
            end
            default: begin
                image.push_back(8'($urandom_range(1, 255)));
                push_random(2);
            end
        endcase
        push_random(19);                      // rest of the header and the length size byte
        n_arrays = $urandom_range(0, 3);
        image.push_back(8'(n_arrays));
        for (int a = 0; a < n_arrays; a++) begin
            push_random(1);                   // array type
            n_units = $urandom_range(0, 3);
            image.push_back(8'h00);
            image.push_back(8'(n_units));
            for (int u = 0; u < n_units; u++) begin
                unit_len = $urandom_range(0, 6);
                // now and then a size far beyond the data that follows
                image.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
                image.push_back(8'(unit_len));
                push_random(unit_len);
            end
        end
        push_random($urandom_range(0, 2));    // padding after the last array
        full = image.size();
        form = $urandom_range(0, 9);
        if (form <= 5) begin
            len = 16'(full);
            push_random($urandom_range(0, 2));    // bytes past the length
            send_image(image.size(), len);
        end else if (form == 6) begin
            send_image(full, 16'(full - $urandom_range(1, 3)));
        end else if (form == 7) begin
            send_image(full, 16'($urandom_range(full, 65535)));
        end else begin
            send_image($urandom_range(1, full), 16'(full));
        end
    endtask

    // annex b input of more than 22 bytes passes through once byte 2 decides
    task automatic annexb_buffer();
        int n;
        n = $urandom_range(23, 40);
        image.delete();
        image.push_back(8'h00);
        image.push_back(8'h00);
        image.push_back(8'($urandom_range(0, 1)));
        push_random(n - 3);
        if ($urandom_range(0, 3) == 0)
            send_image(n, 16'($urandom_range(n, 65535)));
        else
            send_image(n, 16'(n));
    endtask

    // 4 to 22 bytes go through untouched, extra bytes past the length are dropped
    task automatic short_buffer();
        int n;
        n = $urandom_range(4, 22);
        image.delete();
        push_random(n + $urandom_range(0, 2));
        send_image(image.size(), 16'(n));
    endtask

    task automatic tiny_buffer();
        image.delete();
        push_random($urandom_range(1, 4));
        send_image(image.size(), 16'($urandom_range(0, 3)));
    endtask

    // long buffer cut off while the first bytes are still held
    task automatic cut_buffer();
        image.delete();
        if ($urandom_range(0, 1) == 0) begin
            image.push_back(8'h00);
            image.push_back(8'h00);
        end else begin
            push_random(2);
        end
        send_image($urandom_range(1, 2), 16'($urandom_range(23, 65535)));
    endtask

    // free-form words, then an end flag so the next buffer starts clean
    task automatic noise_words();
        int          n;
        logic [15:0] len;
        n = $urandom_range(3, 10);
        for (int i = 0; i < n; i++) begin
            len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
            send_word(8'($urandom), len, $urandom_range(0, 3) == 0);
        end
        send_word(8'($urandom), 16'($urandom), 1'b1);
    endtask

    initial begin
        int  pick;
        bit  held_off;
        bit  paused;
        held_off = 1'b0;
        paused = 1'b0;
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: too short with zero and three bytes of length
        send_word(8'hFF, 16'd0, 1'b1);
        send_word(8'h00, 16'd3, 1'b0);
        send_word(8'hFF, 16'd3, 1'b0);
        send_word(8'h80, 16'd3, 1'b1);
        // shortest pass-through with extreme bytes
        send_word(8'h00, 16'd4, 1'b0);
        send_word(8'hFF, 16'd4, 1'b0);
        send_word(8'hAA, 16'd4, 1'b0);
        send_word(8'h55, 16'd4, 1'b1);
        // early end while holding: one byte, then two
        send_word(8'h80, 16'hFFFF, 1'b1);
        send_word(8'h00, 16'd23, 1'b0);
        send_word(8'h00, 16'd23, 1'b1);
        // start code prefixes release the held bytes
        send_word(8'h00, 16'd23, 1'b0);
        send_word(8'h00, 16'd23, 1'b0);
        send_word(8'h01, 16'd23, 1'b0);
        send_word(8'h7F, 16'd23, 1'b1);
        send_word(8'h00, 16'd23, 1'b0);
        send_word(8'h00, 16'd23, 1'b0);
        send_word(8'h00, 16'd23, 1'b1);

        // random buffers, mostly well-formed hvcc records
        while (words_sent < TOTAL_WORDS) begin
            if (!held_off && words_sent >= HOLD_AT) begin
                held_off = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && words_sent >= DRAIN_AT) begin
                paused = 1'b1;
                drain_results();
            end
            if (words_sent >= CALM_AT)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                hvcc_buffer();
            else if (pick < 65)
                annexb_buffer();
            else if (pick < 75)
                short_buffer();
            else if (pick < 83)
                tiny_buffer();
            else if (pick < 90)
                cut_buffer();
            else
                noise_words();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("[hvcc_to_annexb_converter] OK");
        else
            $display("[hvcc_to_annexb_converter] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/h2a_pkg.sv
rtl/core/h2a_parser.sv
rtl/core/hvcc_to_annexb_converter.sv
dv/hvcc_to_annexb_converter_test.sv
